FILE: rtl/core/lmrs_pkg.sv
// ----------------------------------------------------------------------------
// lmrs_pkg: shared types and constants for the LED matrix row serializer
// Port word bit layout, register indexes, back-end step codes and the
// descriptor that the front end hands to the back end.
// ----------------------------------------------------------------------------
`default_nettype none

package lmrs_pkg;

  // Configuration register indexes
  localparam logic REG_ROW_LENGTH = 1'b0;
  localparam logic REG_ROW_TOTAL  = 1'b1;

  // Register widths
  localparam int ROW_LENGTH_W = 9;
  localparam int ROW_TOTAL_W  = 5;
  localparam int CFG_DATA_W   = 9;

  // Rows per frame never exceed this
  localparam logic [ROW_TOTAL_W-1:0] ROW_LIMIT = 5'd16;
  // Pixels are shifted in groups of four
  localparam int GROUP = 4;

  // Control bits in port word bits 2..0 (CLK, WE, AE)
  localparam logic [2:0] CTL_NONE  = 3'b000;
  localparam logic [2:0] CTL_AE    = 3'b001;
  localparam logic [2:0] CTL_AE_WE = 3'b011;
  localparam logic [2:0] CTL_CLK   = 3'b100;

  // Back-end word sequence for one pixel
  localparam logic [2:0] STEP_DATA       = 3'd0;
  localparam logic [2:0] STEP_CLOCK      = 3'd1;
  localparam logic [2:0] STEP_ROW_BARE   = 3'd2;
  localparam logic [2:0] STEP_ROW_AE     = 3'd3;
  localparam logic [2:0] STEP_ROW_WE     = 3'd4;
  localparam logic [2:0] STEP_ROW_AE_END = 3'd5;
  localparam logic [2:0] STEP_ROW_END    = 3'd6;
  localparam logic [2:0] STEP_FLIP       = 3'd7;

  // Queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_AW    = 1;
  localparam int QUEUE_CW    = 2;

  // One classified pixel
  typedef struct packed {
    logic [3:0] nibble;     // pixel data bits
    logic       sel;        // buffer select while this pixel was shifted
    logic [3:0] row;        // row index for the latch words
    logic       row_end;    // pixel closes a row
    logic       frame_end;  // pixel closes a frame
  } lmrs_desc_t;

endpackage

`default_nettype wire

FILE: rtl/core/led_matrix_row_serializer.sv
// ----------------------------------------------------------------------------
// led_matrix_row_serializer: LED panel port word generator
// Channels:
//   channel   handshake          payload
//   pixels    push / full        pixel_byte[7:0]
//   words     pop / empty        port_word[7:0], run_last
//   config    cfg_we             cfg_index, cfg_data[8:0]
// Each pixel gives two words, seven at a row end, eight at a frame end; the
// back-end sequencer sends one word per cycle while pop is asserted. A pixel
// is taken while the two-entry queue has room, even while the sequencer is
// stalled on pop. Reset (rst, synchronous) clears positions, buffer select and
// the queue; registers return to 64 and 16.
// ----------------------------------------------------------------------------
`default_nettype none

module led_matrix_row_serializer #(
  parameter int MAX_ROW_PIXELS = 256
) (
  input  wire                              clk,
  input  wire                              rst,
  input  wire                              cfg_we,
  input  wire                              cfg_index,
  input  wire  [lmrs_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  wire                              push,
  output logic                             full,
  input  wire  [7:0]                       pixel_byte,
  output logic                             empty,
  input  wire                              pop,
  output logic [7:0]                       port_word,
  output logic                             run_last
);
  import lmrs_pkg::*;

  logic [ROW_LENGTH_W-1:0] row_length;
  logic [ROW_TOTAL_W-1:0]  row_total;
  logic                    in_xfer;
  lmrs_desc_t              front_desc;
  lmrs_desc_t              q_data;
  logic                    q_empty;
  logic                    q_pop;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      row_length <= ROW_LENGTH_W'(64);
      row_total  <= ROW_TOTAL_W'(16);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ROW_LENGTH: row_length <= cfg_data[ROW_LENGTH_W-1:0];
        REG_ROW_TOTAL:  row_total  <= cfg_data[ROW_TOTAL_W-1:0];
        default:        ;
      endcase
    end
  end

  assign in_xfer = push && !full;

  lmrs_front #(
    .MAX_ROW_PIXELS(MAX_ROW_PIXELS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .row_length (row_length),
    .row_total  (row_total),
    .in_xfer    (in_xfer),
    .pixel_byte (pixel_byte),
    .desc       (front_desc)
  );

  lmrs_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (in_xfer),
    .wr_data (front_desc),
    .full    (full),
    .rd_en   (q_pop),
    .rd_data (q_data),
    .empty   (q_empty)
  );

  lmrs_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_data    (q_data),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .port_word (port_word),
    .run_last  (run_last),
    .empty     (empty),
    .pop       (pop)
  );

endmodule

`default_nettype wire

FILE: rtl/core/lmrs_queue.sv
// ----------------------------------------------------------------------------
// lmrs_queue: short descriptor queue
// Two-entry circular buffer between the front end and the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module lmrs_queue (
  input  wire                      clk,
  input  wire                      rst,
  input  wire                      wr_en,
  input  lmrs_pkg::lmrs_desc_t     wr_data,
  output logic                     full,
  input  wire                      rd_en,
  output lmrs_pkg::lmrs_desc_t     rd_data,
  output logic                     empty
);
  import lmrs_pkg::*;

  lmrs_desc_t            mem [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0]   wr_ptr;
  logic [QUEUE_AW-1:0]   rd_ptr;
  logic [QUEUE_CW-1:0]   count;

  assign full    = (count == QUEUE_CW'(QUEUE_DEPTH));
  assign empty   = (count == '0);
  assign rd_data = mem[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (rd_en) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (wr_en && !rd_en) begin
        count <= count + 1'b1;
      end else if (!wr_en && rd_en) begin
        count <= count - 1'b1;
      end
    end
  end

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= QUEUE_CW'(QUEUE_DEPTH))
    else $error("queue fill count above depth");
`endif

endmodule

`default_nettype wire

FILE: rtl/core/lmrs_front.sv
// ----------------------------------------------------------------------------
// lmrs_front: pixel classifier
// Tracks column, row and buffer select, and tags each accepted pixel with
// whether it closes a row or a frame.
// ----------------------------------------------------------------------------
`default_nettype none

module lmrs_front #(
  parameter int MAX_ROW_PIXELS = 256
) (
  input  wire                                     clk,
  input  wire                                     rst,
  input  wire  [lmrs_pkg::ROW_LENGTH_W-1:0]       row_length,
  input  wire  [lmrs_pkg::ROW_TOTAL_W-1:0]        row_total,
  input  wire                                     in_xfer,
  input  wire  [7:0]                              pixel_byte,
  output lmrs_pkg::lmrs_desc_t                    desc
);
  import lmrs_pkg::*;

  localparam int CW = $clog2(MAX_ROW_PIXELS + 1);
  localparam int EW = (CW > 11) ? CW : 11;

  logic [CW-1:0]          column_position;
  logic [3:0]             row_position;
  logic                   buffer_select;

  logic [10:0]            len_round;
  logic [EW-1:0]          len_eff;
  logic [ROW_TOTAL_W-1:0] rows_eff;
  logic [CW-1:0]          column_inc;
  logic [ROW_TOTAL_W-1:0] row_inc;
  logic                   row_end;
  logic                   frame_end;

  // effective row length: round up to a group, zero means one group, saturate
  always_comb begin
    len_round = (11'(row_length) + 11'(GROUP - 1)) & ~11'(GROUP - 1);
    if (len_round == '0) begin
      len_eff = EW'(GROUP);
    end else if (EW'(len_round) > EW'(MAX_ROW_PIXELS)) begin
      len_eff = EW'(MAX_ROW_PIXELS);
    end else begin
      len_eff = EW'(len_round);
    end
  end

  // effective rows per frame
  always_comb begin
    if (row_total == '0) begin
      rows_eff = ROW_TOTAL_W'(1);
    end else if (row_total > ROW_LIMIT) begin
      rows_eff = ROW_LIMIT;
    end else begin
      rows_eff = row_total;
    end
  end

  assign column_inc = column_position + 1'b1;
  assign row_inc    = ROW_TOTAL_W'(row_position) + 1'b1;
  assign row_end    = (EW'(column_inc) >= len_eff);
  assign frame_end  = row_end && (row_inc >= rows_eff);

  // descriptor for the pixel on the input
  always_comb begin
    desc.nibble    = pixel_byte[3:0];
    desc.sel       = buffer_select;
    desc.row       = row_position;
    desc.row_end   = row_end;
    desc.frame_end = frame_end;
  end

  // position state
  always_ff @(posedge clk) begin
    if (rst) begin
      column_position <= '0;
      row_position    <= '0;
      buffer_select   <= 1'b0;
    end else if (in_xfer) begin
      if (row_end) begin
        column_position <= '0;
        if (frame_end) begin
          row_position  <= '0;
          buffer_select <= ~buffer_select;
        end else begin
          row_position  <= row_inc[3:0];
        end
      end else begin
        column_position <= column_inc;
      end
    end
  end

`ifndef ASSERT_OFF
  a_column_bound: assert property (@(posedge clk) disable iff (rst)
    EW'(column_position) < EW'(MAX_ROW_PIXELS))
    else $error("column position reached row pixel limit");
`endif

endmodule

`default_nettype wire

FILE: rtl/core/lmrs_back.sv
// ----------------------------------------------------------------------------
// lmrs_back: port word sequencer
// Takes one descriptor at a time and walks through its port words:
// data, clock, then the row latch words and the buffer flip word if tagged.
// ----------------------------------------------------------------------------
`default_nettype none

module lmrs_back (
  input  wire                     clk,
  input  wire                     rst,
  input  lmrs_pkg::lmrs_desc_t    q_data,
  input  wire                     q_empty,
  output logic                    q_pop,
  output logic [7:0]              port_word,
  output logic                    run_last,
  output logic                    empty,
  input  wire                     pop
);
  import lmrs_pkg::*;

  logic        busy;
  logic [2:0]  step;
  lmrs_desc_t  cur;
  logic [2:0]  last_step;
  logic        is_last;
  logic        take;
  logic        load;

  always_comb begin
    if (cur.frame_end) begin
      last_step = STEP_FLIP;
    end else if (cur.row_end) begin
      last_step = STEP_ROW_END;
    end else begin
      last_step = STEP_CLOCK;
    end
  end

  assign is_last  = (step == last_step);
  assign empty    = ~busy;
  assign take     = busy && pop;
  assign load     = !q_empty && (!busy || (take && is_last));
  assign q_pop    = load;
  assign run_last = is_last;

  // word for the current step
  always_comb begin
    case (step)
      STEP_DATA:       port_word = {cur.sel, cur.nibble, CTL_NONE};
      STEP_CLOCK:      port_word = {cur.sel, cur.nibble, CTL_CLK};
      STEP_ROW_BARE:   port_word = {cur.sel, cur.row, CTL_NONE};
      STEP_ROW_AE:     port_word = {cur.sel, cur.row, CTL_AE};
      STEP_ROW_WE:     port_word = {cur.sel, cur.row, CTL_AE_WE};
      STEP_ROW_AE_END: port_word = {cur.sel, cur.row, CTL_AE};
      STEP_ROW_END:    port_word = {cur.sel, cur.row, CTL_NONE};
      STEP_FLIP:       port_word = {~cur.sel, 4'd0, CTL_NONE};
      default:         port_word = '0;
    endcase
  end

  // sequencer control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      step <= STEP_DATA;
    end else if (load) begin
      busy <= 1'b1;
      step <= STEP_DATA;
    end else if (take && is_last) begin
      busy <= 1'b0;
    end else if (take) begin
      step <= step + 1'b1;
    end
  end

  // current descriptor
  always_ff @(posedge clk) begin
    if (load) begin
      cur <= q_data;
    end
  end

`ifndef ASSERT_OFF
  a_step_bound: assert property (@(posedge clk) disable iff (rst)
    busy |-> (step <= last_step))
    else $error("sequencer stepped past the last word");

  a_mid_stays: assert property (@(posedge clk) disable iff (rst)
    (take && !is_last) |=> busy)
    else $error("sequencer dropped a pixel mid-sequence");

  a_load_from_data: assert property (@(posedge clk) disable iff (rst)
    load |=> (busy && step == STEP_DATA))
    else $error("new pixel did not start at the data word");
`endif

endmodule

`default_nettype wire
